### hdl/text_run_width_measure_top_defines.svh
// ----------------------------------------------------------------------------
// text_run_width_measure_top_defines.svh
// Assertion macros shared by the text run width measure modules
// ----------------------------------------------------------------------------
`ifndef TEXT_RUN_WIDTH_MEASURE_TOP_DEFINES_SVH
`define TEXT_RUN_WIDTH_MEASURE_TOP_DEFINES_SVH

// clocked property, off while reset is asserted
`define TRWM_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication form: when cond holds, then must hold in the same cycle
`define TRWM_ASSERT_IMPL(lbl, cond, then_expr, msg) \
  `TRWM_ASSERT_CLK(lbl, (cond) |-> (then_expr), msg)

// implication form: when cond holds, then must hold in the next cycle
`define TRWM_ASSERT_NEXT(lbl, cond, then_expr, msg) \
  `TRWM_ASSERT_CLK(lbl, (cond) |=> (then_expr), msg)

`endif

### hdl/trwm_pkg.sv
// ----------------------------------------------------------------------------
// trwm_pkg
// Shared types, constants and codes of the text run width measure block
// ----------------------------------------------------------------------------
package trwm_pkg;

  // glyph table geometry
  localparam int GLYPH_SLOTS = 256;
  localparam int SLOT_W      = $clog2(GLYPH_SLOTS);
  localparam int CNT_W       = SLOT_W + 1;
  localparam int HI_W        = CNT_W + 1;

  // field widths
  localparam int CMD_W    = 2;
  localparam int INDEX_W  = 8;
  localparam int CODE_W   = 16;
  localparam int GWIDTH_W = 8;
  localparam int TWIDTH_W = 23;
  localparam int HEIGHT_W = 8;
  localparam int GCOUNT_W = 9;
  localparam int CFG_W    = 9;
  localparam int REG_W    = 2;

  // accumulator and per-character step widths
  localparam int SUM_W  = 24;
  localparam int STEP_W = 10;
  localparam int EXT_W  = SUM_W + 1;

  localparam logic [CODE_W-1:0] SPACE_CODE = 16'h0020;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // memory entry: code in the upper bits, advance width in the lower
  localparam int ENTRY_W = CODE_W + GWIDTH_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_MEASURE = 2'd1,
    CMD_EMPTY   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [REG_W-1:0] {
    REG_SPACE_ADV  = 2'd0,
    REG_SPACING    = 2'd1,
    REG_LINE_H     = 2'd2,
    REG_GLYPH_CNT  = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MISS,
    ST_ACC,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [7:0]          space_adv;
    logic signed [7:0]   spacing;
    logic [HEIGHT_W-1:0] line_h;
    logic [GCOUNT_W-1:0] glyph_cnt;
  } cfg_t;

  // commands from the search sequencer to the accumulator
  typedef struct packed {
    logic                     add;
    logic signed [STEP_W-1:0] step;
    logic                     emit;
    logic                     zero;
  } acc_ctl_t;

endpackage

### hdl/trwm_in_if.sv
// ----------------------------------------------------------------------------
// trwm_in_if
// Input channel: load, measure and empty-string words
// ----------------------------------------------------------------------------
interface trwm_in_if;
  logic                           valid;
  logic                           ready;
  logic [trwm_pkg::CMD_W-1:0]     command;
  logic [trwm_pkg::INDEX_W-1:0]   entry_index;
  logic [trwm_pkg::CODE_W-1:0]    entry_code;
  logic [trwm_pkg::GWIDTH_W-1:0]  entry_width;
  logic [trwm_pkg::CODE_W-1:0]    char_code;
  logic                           last_char;

  modport source (
    output valid, command, entry_index, entry_code, entry_width, char_code, last_char,
    input  ready
  );

  modport sink (
    input  valid, command, entry_index, entry_code, entry_width, char_code, last_char,
    output ready
  );
endinterface

### hdl/trwm_out_if.sv
// ----------------------------------------------------------------------------
// trwm_out_if
// Output channel: measured width and height words
// ----------------------------------------------------------------------------
interface trwm_out_if;
  logic                           valid;
  logic                           ready;
  logic [trwm_pkg::TWIDTH_W-1:0]  text_width;
  logic [trwm_pkg::HEIGHT_W-1:0]  text_height;

  modport source (
    output valid, text_width, text_height,
    input  ready
  );

  modport sink (
    input  valid, text_width, text_height,
    output ready
  );
endinterface

### hdl/trwm_ram.sv
// ----------------------------------------------------------------------------
// trwm_ram
// Simple dual-port RAM, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module trwm_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 24
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered output
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/trwm_ctrl.sv
// ----------------------------------------------------------------------------
// trwm_ctrl
// Input decode, glyph table writes and binary search sequencer
// ----------------------------------------------------------------------------
`include "text_run_width_measure_top_defines.svh"

module trwm_ctrl (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  trwm_in_if.sink                                  in_s,
  input  trwm_pkg::cfg_t                           cfg_i,
  output logic                                     ram_we_o,
  output logic [trwm_pkg::SLOT_W-1:0]              ram_waddr_o,
  output logic [trwm_pkg::ENTRY_W-1:0]             ram_wdata_o,
  output logic [trwm_pkg::SLOT_W-1:0]              ram_raddr_o,
  input  logic [trwm_pkg::ENTRY_W-1:0]             ram_rdata_i,
  output trwm_pkg::acc_ctl_t                       acc_ctl_o,
  input  logic                                     out_free_i
);

  trwm_pkg::state_e state_q, state_d;

  logic [trwm_pkg::CODE_W-1:0]            code_q, code_d;
  logic                                   last_q, last_d;
  logic                                   zero_q, zero_d;
  logic [trwm_pkg::CNT_W-1:0]             lo_q, lo_d;
  logic signed [trwm_pkg::HI_W-1:0]       hi_q, hi_d;
  logic [trwm_pkg::SLOT_W-1:0]            mid_q, mid_d;
  logic signed [trwm_pkg::STEP_W-1:0]     step_q, step_d;

  logic [trwm_pkg::CNT_W-1:0]             cnt;
  logic [trwm_pkg::CODE_W-1:0]            probe_code;
  logic [trwm_pkg::GWIDTH_W-1:0]          probe_width;
  logic signed [trwm_pkg::STEP_W-1:0]     glyph_step;
  logic signed [trwm_pkg::STEP_W-1:0]     space_step;
  logic signed [trwm_pkg::STEP_W-1:0]     spacing_ext;
  logic [trwm_pkg::CNT_W-1:0]             lo_n;
  logic signed [trwm_pkg::HI_W-1:0]       hi_n;
  logic [trwm_pkg::CNT_W:0]               mid_sum;
  logic [trwm_pkg::SLOT_W-1:0]            mid_n;
  logic                                   range_empty;
  logic [trwm_pkg::CNT_W-1:0]             mid_ext;

  // valid table size, capped at the table depth
  always_comb begin
    if (int'(cfg_i.glyph_cnt) > trwm_pkg::GLYPH_SLOTS) begin
      cnt = trwm_pkg::CNT_W'(trwm_pkg::GLYPH_SLOTS);
    end else begin
      cnt = trwm_pkg::CNT_W'(cfg_i.glyph_cnt);
    end
  end

  // per-character advance terms
  assign probe_code  = ram_rdata_i[trwm_pkg::ENTRY_W-1:trwm_pkg::GWIDTH_W];
  assign probe_width = ram_rdata_i[trwm_pkg::GWIDTH_W-1:0];
  assign spacing_ext = {{(trwm_pkg::STEP_W-8){cfg_i.spacing[7]}}, cfg_i.spacing};
  assign glyph_step  = $signed({2'b00, probe_width}) + spacing_ext;
  assign space_step  = $signed({2'b00, cfg_i.space_adv}) + spacing_ext;

  // narrowing of the search range after a probe that missed
  always_comb begin
    if (probe_code > code_q) begin
      lo_n = lo_q;
      hi_n = $signed({2'b00, mid_q}) - trwm_pkg::HI_W'(1);
    end else begin
      lo_n = {1'b0, mid_q} + trwm_pkg::CNT_W'(1);
      hi_n = hi_q;
    end
    range_empty = $signed({1'b0, lo_n}) > hi_n;
    mid_sum     = {1'b0, hi_n[trwm_pkg::CNT_W-1:0]} + {1'b0, lo_n};
    mid_n       = mid_sum[trwm_pkg::SLOT_W:1];
  end

  // table write straight from the input word
  assign ram_waddr_o = trwm_pkg::SLOT_W'(in_s.entry_index);
  assign ram_wdata_o = {in_s.entry_code, in_s.entry_width};

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= trwm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // search datapath registers
  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    last_q <= last_d;
    zero_q <= zero_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    step_q <= step_d;
  end

  // next state and outputs
  always_comb begin
    state_d     = state_q;
    code_d      = code_q;
    last_d      = last_q;
    zero_d      = zero_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    step_d      = step_q;
    in_s.ready  = 1'b0;
    ram_we_o    = 1'b0;
    ram_raddr_o = mid_q;
    acc_ctl_o   = '0;

    unique case (state_q)
      trwm_pkg::ST_IDLE: begin
        in_s.ready = 1'b1;
        if (in_s.valid) begin
          unique case (trwm_pkg::cmd_e'(in_s.command))
            trwm_pkg::CMD_LOAD: begin
              ram_we_o = int'(in_s.entry_index) < trwm_pkg::GLYPH_SLOTS;
            end
            trwm_pkg::CMD_MEASURE: begin
              code_d = in_s.char_code;
              last_d = in_s.last_char;
              zero_d = 1'b0;
              if (in_s.char_code == trwm_pkg::SPACE_CODE) begin
                step_d  = space_step;
                state_d = trwm_pkg::ST_ACC;
              end else begin
                lo_d = '0;
                hi_d = $signed({1'b0, cnt}) - trwm_pkg::HI_W'(1);
                if (cnt == '0) begin
                  mid_d       = '0;
                  ram_raddr_o = '0;
                  state_d     = trwm_pkg::ST_MISS;
                end else begin
                  mid_d       = trwm_pkg::SLOT_W'(cnt >> 1);
                  ram_raddr_o = trwm_pkg::SLOT_W'(cnt >> 1);
                  state_d     = trwm_pkg::ST_READ;
                end
              end
            end
            trwm_pkg::CMD_EMPTY: begin
              zero_d  = 1'b1;
              state_d = trwm_pkg::ST_EMIT;
            end
            default: begin
            end
          endcase
        end
      end

      // one probe per cycle, data of the previous address is valid now
      trwm_pkg::ST_READ: begin
        if (probe_code == code_q) begin
          step_d  = glyph_step;
          state_d = trwm_pkg::ST_ACC;
        end else if (range_empty) begin
          mid_d       = '0;
          ram_raddr_o = '0;
          state_d     = trwm_pkg::ST_MISS;
        end else begin
          lo_d        = lo_n;
          hi_d        = hi_n;
          mid_d       = mid_n;
          ram_raddr_o = mid_n;
        end
      end

      // miss falls back to entry zero
      trwm_pkg::ST_MISS: begin
        step_d  = glyph_step;
        state_d = trwm_pkg::ST_ACC;
      end

      trwm_pkg::ST_ACC: begin
        acc_ctl_o.add  = 1'b1;
        acc_ctl_o.step = step_q;
        state_d        = last_q ? trwm_pkg::ST_EMIT : trwm_pkg::ST_IDLE;
      end

      // wait for the output register to free up
      trwm_pkg::ST_EMIT: begin
        if (out_free_i) begin
          acc_ctl_o.emit = 1'b1;
          acc_ctl_o.zero = zero_q;
          state_d        = trwm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = trwm_pkg::ST_IDLE;
      end
    endcase
  end

  assign mid_ext = {1'b0, mid_q};

  // checks
  `TRWM_ASSERT_IMPL(a_probe_in_range, state_q == trwm_pkg::ST_READ, mid_ext < cnt, "probe index outside valid table")
  `TRWM_ASSERT_CLK(a_add_emit_excl, !(acc_ctl_o.add && acc_ctl_o.emit), "add and emit issued together")
  `TRWM_ASSERT_NEXT(a_miss_reads_zero, state_q == trwm_pkg::ST_READ && state_d == trwm_pkg::ST_MISS, mid_q == '0, "miss did not select entry zero")

endmodule

### hdl/trwm_accum.sv
// ----------------------------------------------------------------------------
// trwm_accum
// Saturating width accumulator and output register
// ----------------------------------------------------------------------------
`include "text_run_width_measure_top_defines.svh"

module trwm_accum (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  trwm_pkg::acc_ctl_t acc_ctl_i,
  input  trwm_pkg::cfg_t     cfg_i,
  output logic               out_free_o,
  trwm_out_if.source         out_m
);

  logic signed [trwm_pkg::SUM_W-1:0]  sum_q, sum_d;
  logic                               out_valid_q, out_valid_d;
  logic [trwm_pkg::TWIDTH_W-1:0]      out_width_q, out_width_d;
  logic [trwm_pkg::HEIGHT_W-1:0]      out_height_q, out_height_d;

  logic signed [trwm_pkg::EXT_W-1:0]  add_ext;
  logic signed [trwm_pkg::EXT_W-1:0]  fin_ext;
  logic signed [trwm_pkg::EXT_W-1:0]  base_ext;
  logic signed [trwm_pkg::EXT_W-1:0]  max_ext;
  logic signed [trwm_pkg::EXT_W-1:0]  min_ext;
  logic signed [trwm_pkg::SUM_W-1:0]  add_sat;
  logic [trwm_pkg::TWIDTH_W-1:0]      fin_width;

  assign max_ext = {trwm_pkg::SUM_MAX[trwm_pkg::SUM_W-1], trwm_pkg::SUM_MAX};
  assign min_ext = {trwm_pkg::SUM_MIN[trwm_pkg::SUM_W-1], trwm_pkg::SUM_MIN};

  // running sum plus step, saturated
  always_comb begin
    add_ext = {sum_q[trwm_pkg::SUM_W-1], sum_q}
            + {{(trwm_pkg::EXT_W-trwm_pkg::STEP_W){acc_ctl_i.step[trwm_pkg::STEP_W-1]}},
               acc_ctl_i.step};
    if (add_ext > max_ext) begin
      add_sat = trwm_pkg::SUM_MAX;
    end else if (add_ext < min_ext) begin
      add_sat = trwm_pkg::SUM_MIN;
    end else begin
      add_sat = add_ext[trwm_pkg::SUM_W-1:0];
    end
  end

  // final width: sum less one spacing, saturated, clamped at zero
  always_comb begin
    base_ext = acc_ctl_i.zero ? '0 : {sum_q[trwm_pkg::SUM_W-1], sum_q};
    fin_ext  = base_ext
             - {{(trwm_pkg::EXT_W-8){cfg_i.spacing[7]}}, cfg_i.spacing};
    if (fin_ext < 0) begin
      fin_width = '0;
    end else if (fin_ext > max_ext) begin
      fin_width = trwm_pkg::SUM_MAX[trwm_pkg::TWIDTH_W-1:0];
    end else begin
      fin_width = fin_ext[trwm_pkg::TWIDTH_W-1:0];
    end
  end

  // next values
  always_comb begin
    sum_d        = sum_q;
    out_valid_d  = out_valid_q;
    out_width_d  = out_width_q;
    out_height_d = out_height_q;
    if (out_valid_q && out_m.ready) begin
      out_valid_d = 1'b0;
    end
    if (acc_ctl_i.add) begin
      sum_d = add_sat;
    end
    if (acc_ctl_i.emit) begin
      sum_d        = '0;
      out_valid_d  = 1'b1;
      out_width_d  = fin_width;
      out_height_d = cfg_i.line_h;
    end
  end

  // control and sum registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output word payload
  always_ff @(posedge clk_i) begin
    out_width_q  <= out_width_d;
    out_height_q <= out_height_d;
  end

  assign out_free_o        = !out_valid_q || out_m.ready;
  assign out_m.valid       = out_valid_q;
  assign out_m.text_width  = out_width_q;
  assign out_m.text_height = out_height_q;

  // checks
  `TRWM_ASSERT_IMPL(a_emit_when_free, acc_ctl_i.emit, !out_valid_q || out_m.ready, "result overwrites a pending word")
  `TRWM_ASSERT_NEXT(a_sum_cleared, acc_ctl_i.emit, sum_q == '0, "sum not cleared after result")

endmodule

### hdl/text_run_width_measure_top.sv
// ----------------------------------------------------------------------------
// text_run_width_measure_top
// String width of a proportional font over a sorted glyph table
// ----------------------------------------------------------------------------
// One word is processed at a time. A load is written straight into the
// glyph table. A space goes from idle to the accumulate state; a looked-up
// character first runs the binary search probes (at most log2(glyph_count)
// + 1, none for an empty table) and a miss adds one more read of entry zero.
// The glyph memory has a single read port, which serves one probe per cycle
// and whose read data is registered. The last character of a string and an
// empty-string word then pass through the emit state, which loads the result
// and waits there while the previous result is still waiting on the output.
// ----------------------------------------------------------------------------
module text_run_width_measure_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  trwm_in_if.sink                     in_s,
  trwm_out_if.source                  out_m,
  input  logic                        cfg_we_i,
  input  logic [trwm_pkg::REG_W-1:0]  cfg_idx_i,
  input  logic [trwm_pkg::CFG_W-1:0]  cfg_wdata_i
);

  trwm_pkg::cfg_t     cfg_q;
  trwm_pkg::acc_ctl_t acc_ctl;
  logic               out_free;

  logic                            ram_we;
  logic [trwm_pkg::SLOT_W-1:0]     ram_waddr;
  logic [trwm_pkg::ENTRY_W-1:0]    ram_wdata;
  logic [trwm_pkg::SLOT_W-1:0]     ram_raddr;
  logic [trwm_pkg::ENTRY_W-1:0]    ram_rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (trwm_pkg::reg_e'(cfg_idx_i))
        trwm_pkg::REG_SPACE_ADV: cfg_q.space_adv <= cfg_wdata_i[7:0];
        trwm_pkg::REG_SPACING:   cfg_q.spacing   <= $signed(cfg_wdata_i[7:0]);
        trwm_pkg::REG_LINE_H:    cfg_q.line_h    <= cfg_wdata_i[trwm_pkg::HEIGHT_W-1:0];
        trwm_pkg::REG_GLYPH_CNT: cfg_q.glyph_cnt <= cfg_wdata_i[trwm_pkg::GCOUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // glyph table: code and advance width per slot
  trwm_ram #(
    .DEPTH(trwm_pkg::GLYPH_SLOTS),
    .WIDTH(trwm_pkg::ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // search sequencer
  trwm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_s        (in_s),
    .cfg_i       (cfg_q),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .acc_ctl_o   (acc_ctl),
    .out_free_i  (out_free)
  );

  // accumulator and result register
  trwm_accum u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_ctl_i  (acc_ctl),
    .cfg_i      (cfg_q),
    .out_free_o (out_free),
    .out_m      (out_m)
  );

endmodule

### tb/text_run_width_measure_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_run_width_measure_checker
// Watches both channels and the register port of the width measure block,
// keeps its own glyph table, register copy and running sum, predicts the
// width and height of every finished string and compares each delivered
// word with the oldest prediction.
// ----------------------------------------------------------------------------
module text_run_width_measure_checker
  import trwm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  trwm_in_if               in_mon,
  trwm_out_if              out_mon,
  input  logic             cfg_we_i,
  input  logic [REG_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               results_o
);

  typedef struct packed {
    logic [TWIDTH_W-1:0] width;
    logic [HEIGHT_W-1:0] height;
  } text_size_t;

  // glyph table copy, filled by load words
  logic [CODE_W-1:0]   glyph_code_tab  [GLYPH_SLOTS];
  logic [GWIDTH_W-1:0] glyph_width_tab [GLYPH_SLOTS];

  // register copy
  logic [7:0]          space_adv;
  logic signed [7:0]   spacing;
  logic [HEIGHT_W-1:0] line_h;
  logic [GCOUNT_W-1:0] glyph_cnt;

  int         run_sum;
  text_size_t awaited_sizes[$];
  int         fails   = 0;
  int         checked = 0;

  // clamp to the 24-bit signed range of the accumulator
  function automatic int clamp_sum(input int v);
    if (v > int'(SUM_MAX)) return int'(SUM_MAX);
    if (v < int'(SUM_MIN)) return int'(SUM_MIN);
    return v;
  endfunction

  // binary search from the middle; a miss falls back to slot zero
  function automatic int glyph_slot_for(input logic [CODE_W-1:0] code);
    int n;
    int lo;
    int hi;
    int mid;
    n   = (glyph_cnt > GLYPH_SLOTS) ? GLYPH_SLOTS : int'(glyph_cnt);
    lo  = 0;
    hi  = n - 1;
    mid = n / 2;
    while (lo <= hi) begin
      if (glyph_code_tab[mid] == code) break;
      if (glyph_code_tab[mid] > code) hi = mid - 1;
      else lo = mid + 1;
      mid = (hi + lo) / 2;
    end
    if (lo > hi) mid = 0;
    return mid;
  endfunction

  // final width: sum less one spacing, clamped at zero
  function automatic text_size_t string_size();
    int w;
    w = clamp_sum(run_sum - int'(spacing));
    if (w < 0) w = 0;
    string_size.width  = w[TWIDTH_W-1:0];
    string_size.height = line_h;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] width check: %s got %0d expected %0d", $time, what, got, want);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    text_size_t want;
    int         step;
    if (!rst_ni) begin
      awaited_sizes.delete();
      run_sum      = 0;
      space_adv    = '0;
      spacing      = '0;
      line_h       = '0;
      glyph_cnt    = '0;
      fail_count_o <= 0;
      pending_o    <= 0;
      results_o    <= 0;
    end else begin
      // delivered word against the oldest awaited size
      if (out_mon.valid && out_mon.ready) begin
        checked++;
        if (awaited_sizes.size() == 0) begin
          report_mismatch("word with nothing awaited, width", out_mon.text_width, -1);
        end else begin
          want = awaited_sizes.pop_front();
          if (out_mon.text_width !== want.width)
            report_mismatch("text_width", out_mon.text_width, want.width);
          if (out_mon.text_height !== want.height)
            report_mismatch("text_height", out_mon.text_height, want.height);
        end
      end

      // accepted word updates the table or the running sum
      if (in_mon.valid && in_mon.ready) begin
        case (cmd_e'(in_mon.command))
          CMD_LOAD: begin
            glyph_code_tab[in_mon.entry_index]  = in_mon.entry_code;
            glyph_width_tab[in_mon.entry_index] = in_mon.entry_width;
          end
          CMD_MEASURE: begin
            if (in_mon.char_code == SPACE_CODE)
              step = int'(spacing) + int'(space_adv);
            else
              step = int'(glyph_width_tab[glyph_slot_for(in_mon.char_code)]) + int'(spacing);
            run_sum = clamp_sum(run_sum + step);
            if (in_mon.last_char) begin
              awaited_sizes.push_back(string_size());
              run_sum = 0;
            end
          end
          CMD_EMPTY: begin
            run_sum = 0;
            awaited_sizes.push_back(string_size());
          end
          default: ;
        endcase
      end

      // register writes
      if (cfg_we_i) begin
        case (reg_e'(cfg_idx_i))
          REG_SPACE_ADV: space_adv = cfg_wdata_i[7:0];
          REG_SPACING:   spacing   = cfg_wdata_i[7:0];
          REG_LINE_H:    line_h    = cfg_wdata_i[7:0];
          REG_GLYPH_CNT: glyph_cnt = cfg_wdata_i[GCOUNT_W-1:0];
          default: ;
        endcase
      end

      fail_count_o <= fails;
      pending_o    <= awaited_sizes.size();
      results_o    <= checked;
    end
  end

endmodule

### tb/text_run_width_measure_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_run_width_measure_top_test
// Drives the width measure block with table loads, measured strings and
// empty strings under bursty input and a stalling output, across several
// register settings including the extremes and a long unbroken run of
// spaces; the checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module text_run_width_measure_top_test;
  import trwm_pkg::*;

  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int SETTLE_CYCLES   = 32;
  localparam int RANDOM_PHASES   = 10;
  localparam int WORDS_PER_PHASE = 30;
  localparam int SPACE_RUN_LEN   = 32;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [REG_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;

  int fail_count;
  int awaited_count;
  int widths_checked;

  trwm_in_if  in_w ();
  trwm_out_if out_w ();

  text_run_width_measure_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_s        (in_w),
    .out_m       (out_w),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  text_run_width_measure_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_w),
    .out_mon      (out_w),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (awaited_count),
    .results_o    (widths_checked)
  );

  // sender state and run statistics
  logic [CODE_W-1:0] table_codes [GLYPH_SLOTS];
  int burst_left    = 0;
  bit gaps_on       = 1'b1;
  int loads_sent    = 0;
  int chars_sent    = 0;
  int empties_sent  = 0;
  int settings_used = 0;
  int cycle_count   = 0;

  // receiver stall pattern
  int stall_mode = 0;
  int stall_left = 0;
  int stall_tick = 0;

  // count register value last written, as seen on the register port
  logic [CFG_W-1:0] last_count = '0;
  always @(posedge clk_i) begin
    if (cfg_we && reg_e'(cfg_idx) == REG_GLYPH_CNT) last_count <= cfg_wdata;
  end

  function automatic int cnt_last_written();
    return int'(last_count);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // output side: modes of always ready, coin flips, one in eight, mostly ready
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      0:       out_w.ready <= 1'b1;
      1:       out_w.ready <= 1'($urandom_range(0, 1));
      2:       out_w.ready <= (stall_tick % 8 == 0);
      default: out_w.ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited", cycle_count,
               awaited_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one word on the input channel, in bursts with random gaps between
  task automatic put_word(input cmd_e cmd, input logic [INDEX_W-1:0] idx,
                          input logic [CODE_W-1:0] ecode, input logic [GWIDTH_W-1:0] ew,
                          input logic [CODE_W-1:0] ch, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_w.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_w.valid       <= 1'b1;
    in_w.command     <= cmd;
    in_w.entry_index <= idx;
    in_w.entry_code  <= ecode;
    in_w.entry_width <= ew;
    in_w.char_code   <= ch;
    in_w.last_char   <= last;
    @(posedge clk_i);
    while (!in_w.ready) @(posedge clk_i);
    case (cmd)
      CMD_LOAD:    loads_sent++;
      CMD_MEASURE: chars_sent++;
      CMD_EMPTY:   empties_sent++;
      default: ;
    endcase
  endtask

  task automatic load_glyph(input logic [INDEX_W-1:0] idx, input logic [CODE_W-1:0] code,
                            input logic [GWIDTH_W-1:0] w);
    table_codes[idx] = code;
    put_word(CMD_LOAD, idx, code, w, CODE_W'($urandom_range(0, 65535)),
             1'($urandom_range(0, 1)));
  endtask

  task automatic measure_char(input logic [CODE_W-1:0] ch, input logic last);
    put_word(CMD_MEASURE, INDEX_W'($urandom_range(0, 255)), CODE_W'($urandom_range(0, 65535)),
             GWIDTH_W'($urandom_range(0, 255)), ch, last);
  endtask

  task automatic put_other(input cmd_e cmd);
    put_word(cmd, INDEX_W'($urandom_range(0, 255)), CODE_W'($urandom_range(0, 65535)),
             GWIDTH_W'($urandom_range(0, 255)), CODE_W'($urandom_range(0, 65535)),
             1'($urandom_range(0, 1)));
  endtask

  // stop sending until every awaited width is back and the block has settled
  task automatic wait_idle();
    in_w.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (awaited_count != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_reg(input reg_e r, input logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= r;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_all(input logic [CFG_W-1:0] adv, input logic [CFG_W-1:0] sp,
                         input logic [CFG_W-1:0] lh, input logic [CFG_W-1:0] cnt);
    set_reg(REG_SPACE_ADV, adv);
    set_reg(REG_SPACING, sp);
    set_reg(REG_LINE_H, lh);
    set_reg(REG_GLYPH_CNT, cnt);
    settings_used++;
  endtask

  initial begin : stimulus
    int               sent;
    int               pick;
    int               len;
    int               kind;
    int               hit_span;
    int               slot;
    bit               cut;
    logic [CFG_W-1:0] cnt;
    logic [CODE_W-1:0] ch;
    logic [CODE_W-1:0] lo_code;
    logic [CODE_W-1:0] hi_code;

    rst_ni           = 1'b0;
    in_w.valid       <= 1'b0;
    in_w.command     <= CMD_NONE;
    in_w.entry_index <= '0;
    in_w.entry_code  <= '0;
    in_w.entry_width <= '0;
    in_w.char_code   <= '0;
    in_w.last_char   <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= REG_SPACE_ADV;
    cfg_wdata        <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: small sorted table with the extreme codes and widths
    set_all(9'd3, 9'd2, 9'd16, 9'd8);
    load_glyph(8'd0, 16'h0000, 8'd0);
    load_glyph(8'd1, 16'h0021, 8'd7);
    load_glyph(8'd2, 16'h0041, 8'd255);
    load_glyph(8'd3, 16'h0100, 8'd3);
    load_glyph(8'd4, 16'h1234, 8'd9);
    load_glyph(8'd5, 16'h8000, 8'd4);
    load_glyph(8'd6, 16'hABCD, 8'd128);
    load_glyph(8'd7, 16'hFFFF, 8'd1);
    // hit, space, hit on the highest code as the last character
    measure_char(16'h0041, 1'b0);
    measure_char(SPACE_CODE, 1'b0);
    measure_char(16'hFFFF, 1'b1);
    // miss falls back to slot zero
    measure_char(16'h0042, 1'b1);
    measure_char(16'h0000, 1'b1);
    measure_char(16'hABCD, 1'b1);
    put_other(CMD_EMPTY);
    put_other(CMD_NONE);
    measure_char(SPACE_CODE, 1'b1);
    wait_idle();

    // negative spacing clamps at zero; empty table searches nothing
    set_all(9'd0, 9'h080, 9'd0, 9'd0);
    measure_char(16'h0041, 1'b1);
    put_other(CMD_EMPTY);
    measure_char(SPACE_CODE, 1'b0);
    measure_char(SPACE_CODE, 1'b1);
    wait_idle();

    // full table, sorted ascending
    for (int i = 0; i < GLYPH_SLOTS; i++) begin
      if (i == 0) ch = 16'h0000;
      else if (i == GLYPH_SLOTS - 1) ch = 16'hFFFF;
      else ch = {i[7:0], 8'($urandom_range(0, 255))};
      load_glyph(i[7:0], ch, GWIDTH_W'($urandom_range(0, 255)));
    end
    wait_idle();

    // random phases over several register settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      gaps_on = (p % 3 != 2);
      case (p)
        0: set_all(9'd255, 9'h07F, 9'd255, 9'd256);
        1: set_all(9'd0, 9'h080, 9'd0, 9'd511);
        2: set_all(9'd0, 9'd0, 9'd1, 9'd1);
        3: set_all(CFG_W'($urandom_range(0, 511)), CFG_W'($urandom_range(0, 511)),
                   CFG_W'($urandom_range(0, 511)), 9'd0);
        default: begin
          case ($urandom_range(0, 3))
            0: cnt = CFG_W'($urandom_range(1, 256));
            1: cnt = CFG_W'($urandom_range(257, 511));
            2: cnt = 9'd2;
            default: cnt = CFG_W'($urandom_range(0, 511));
          endcase
          set_all(CFG_W'($urandom_range(0, 511)), CFG_W'($urandom_range(0, 511)),
                  CFG_W'($urandom_range(0, 511)), cnt);
        end
      endcase
      hit_span = 0;
      case (p)
        0, 1: hit_span = GLYPH_SLOTS;
        2:    hit_span = 1;
        3:    hit_span = GLYPH_SLOTS;
        default: hit_span = (cnt_last_written() == 0 || cnt_last_written() > GLYPH_SLOTS)
                            ? GLYPH_SLOTS : cnt_last_written();
      endcase

      sent = 0;
      while (sent < WORDS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          put_other(CMD_EMPTY);
          sent++;
        end else if (pick < 9) begin
          put_other(CMD_NONE);
        end else if (pick < 15) begin
          // table rewrite, mostly keeping the order
          slot    = $urandom_range(0, GLYPH_SLOTS - 1);
          lo_code = (slot == 0) ? 16'h0000 : table_codes[slot - 1];
          hi_code = (slot == GLYPH_SLOTS - 1) ? 16'hFFFF : table_codes[slot + 1];
          if ($urandom_range(0, 3) != 0) ch = CODE_W'($urandom_range(lo_code, hi_code));
          else ch = CODE_W'($urandom_range(0, 65535));
          load_glyph(slot[7:0], ch, GWIDTH_W'($urandom_range(0, 255)));
          sent++;
        end else begin
          // a string of spaces, hits, extremes and misses; some left unfinished
          len = $urandom_range(1, 8);
          cut = ($urandom_range(0, 9) == 0);
          for (int k = 0; k < len; k++) begin
            kind = $urandom_range(0, 99);
            if (kind < 20) ch = SPACE_CODE;
            else if (kind < 75) ch = table_codes[$urandom_range(0, hit_span - 1)];
            else if (kind < 80) ch = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            else ch = CODE_W'($urandom_range(0, 65535));
            measure_char(ch, (k == len - 1) && !cut);
            sent++;
          end
        end
      end
      // close any unfinished string before the next setting
      put_other(CMD_EMPTY);
      wait_idle();
    end

    // a long run of spaces back to back, widest advance and most negative spacing
    gaps_on = 1'b0;
    set_all(9'd255, 9'h080, 9'h05A, 9'd256);
    for (int i = 0; i < SPACE_RUN_LEN; i++) measure_char(SPACE_CODE, i == SPACE_RUN_LEN - 1);
    wait_idle();

    $display("covered %0d loads, %0d characters, %0d empty strings over %0d settings",
             loads_sent, chars_sent, empties_sent, settings_used);
    $display("checked %0d widths, including an unbroken run of %0d spaces",
             widths_checked, SPACE_RUN_LEN);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
